// ----- hw/rtl/tssp_pkg.sv -----
// Package for the time-setting string parser: codes, constants and the character filter.
`timescale 1ns / 1ps
`default_nettype none
package tssp_pkg;

  // operation codes of an input item
  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  // parse status codes
  localparam logic [1:0] STATUS_COLLECT = 2'd0;
  localparam logic [1:0] STATUS_DONE    = 2'd1;
  localparam logic [1:0] STATUS_ABANDON = 2'd2;

  // register indexes, taken from paddr[2] (byte addresses 0 and 4)
  localparam logic REG_STRING_LENGTH = 1'b0;
  localparam logic REG_MAX_TIMEOUTS  = 1'b1;

  localparam int unsigned PADDR_W = 3;

  localparam logic [5:0]  STRING_LENGTH_RST = 6'd30;
  localparam logic [7:0]  MAX_TIMEOUTS_RST  = 8'd100;

  localparam logic [7:0]  SYNC_CHAR    = 8'h24;
  localparam logic [7:0]  DIGIT_ZERO   = 8'h30;
  localparam logic [15:0] WAKEUP_MAX   = 16'hFFFF;
  localparam logic [5:0]  WAKEUP_FIRST = 6'd21;
  localparam logic [5:0]  WAKEUP_LAST  = 6'd25;
  localparam logic [2:0]  FIELD_NONE   = 3'd7;

  // characters kept after sync: 0-9 h m s w d y k u p
  function automatic logic in_accept_set(input logic [7:0] c);
    logic hit;
    hit = 1'b0;
    case (c)
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34,
      8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
      8'h68, 8'h6D, 8'h73, 8'h77, 8'h64,
      8'h79, 8'h6B, 8'h75, 8'h70: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/time_setting_string_parser.sv -----
// Time-setting string parser top level: input register, single-pass update, result register.
//
//  channel | direction | transfer when          | payload
//  in_     | in        | in_valid & !in_stall   | operation, rx_byte
//  out_    | out       | out_valid & !out_stall | echo, led, menu, status, time, date, wakeup
//  cfg     | in (APB)  | psel&penable&pwrite    | string_length @0, max_timeouts @4
//
// One item per cycle sustained unless out_ stalls.
// The parse state updates when an item leaves the input register for the result register.
// A stall on out_ holds the result register; in_stall rises only when both stages are full.
// Synchronous active-low reset clears state and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none
module time_setting_string_parser (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output      logic                            in_stall,
  input  wire logic                            in_operation,
  input  wire logic [7:0]                      in_rx_byte,
  output      logic                            out_valid,
  input  wire logic                            out_stall,
  output      logic                            out_echo_valid,
  output      logic [7:0]                      out_echo_byte,
  output      logic                            out_led_on,
  output      logic                            out_show_menu,
  output      logic [1:0]                      out_status,
  output      logic [23:0]                     out_time_bcd,
  output      logic [31:0]                     out_date_bcd,
  output      logic [15:0]                     out_wakeup_seconds,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [tssp_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [31:0]                     pwdata,
  output      logic [31:0]                     prdata,
  output      logic                            pready
);

  // configuration registers
  logic [5:0] string_length_r;
  logic [7:0] max_timeouts_r;
  logic       cfg_wr;

  // input stage
  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_op_r;
  logic [7:0] s1_byte_r;

  // parse state
  logic        synced_r,  synced_nxt;
  logic [5:0]  count_r,   count_nxt;
  logic [1:0]  digit_r,   digit_nxt;
  logic [2:0]  field_r,   field_nxt;
  logic        led_r,     led_nxt;
  logic [7:0]  tmo_r,     tmo_nxt;
  logic [1:0]  finish_r,  finish_nxt;
  logic [23:0] time_r,    time_nxt;
  logic [31:0] date_r,    date_nxt;
  logic [15:0] wake_r,    wake_nxt;

  // result register
  logic       out_valid_r, out_valid_nxt;
  logic       echo_v_nxt, echo_v_r;
  logic [7:0] echo_b_nxt, echo_b_r;
  logic       menu_nxt,   menu_r;

  logic       adv, take, process;
  logic [7:0] v;
  logic [7:0] hi_byte;
  logic [19:0] wake_sum;
  logic [5:0]  count_inc;
  logic [7:0]  tmo_inc;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      string_length_r <= tssp_pkg::STRING_LENGTH_RST;
      max_timeouts_r  <= tssp_pkg::MAX_TIMEOUTS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        tssp_pkg::REG_STRING_LENGTH: string_length_r <= pwdata[5:0];
        tssp_pkg::REG_MAX_TIMEOUTS:  max_timeouts_r  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      tssp_pkg::REG_STRING_LENGTH: prdata = {26'd0, string_length_r};
      tssp_pkg::REG_MAX_TIMEOUTS:  prdata = {24'd0, max_timeouts_r};
      default: prdata = '0;
    endcase
  end

  // handshake
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;
  assign take     = in_valid && !in_stall;
  assign process  = s1_valid_r && adv;

  always_comb begin
    if (take) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (process) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  assign v         = s1_byte_r - tssp_pkg::DIGIT_ZERO;
  assign hi_byte   = {v[3:0], 4'h0};
  assign wake_sum  = {1'b0, wake_r, 3'b000} + {3'b000, wake_r, 1'b0} + {12'd0, v};
  assign count_inc = count_r + 6'd1;
  assign tmo_inc   = tmo_r + 8'd1;

  // single-pass state update for the item in the input register
  always_comb begin
    synced_nxt = synced_r;
    count_nxt  = count_r;
    digit_nxt  = digit_r;
    field_nxt  = field_r;
    led_nxt    = led_r;
    tmo_nxt    = tmo_r;
    finish_nxt = finish_r;
    time_nxt   = time_r;
    date_nxt   = date_r;
    wake_nxt   = wake_r;
    echo_v_nxt = 1'b0;
    echo_b_nxt = 8'h00;
    menu_nxt   = 1'b0;
    if (finish_r == tssp_pkg::STATUS_COLLECT) begin
      if (s1_op_r == tssp_pkg::OP_TIMEOUT) begin
        if (!synced_r) begin
          tmo_nxt = tmo_inc;
          if (tmo_inc == max_timeouts_r) begin
            finish_nxt = tssp_pkg::STATUS_ABANDON;
            led_nxt    = 1'b0;
          end else begin
            menu_nxt = 1'b1;
          end
        end
      end else if (!synced_r) begin
        if (s1_byte_r == tssp_pkg::SYNC_CHAR) begin
          synced_nxt = 1'b1;
          echo_v_nxt = 1'b1;
          echo_b_nxt = s1_byte_r;
        end
      end else if (tssp_pkg::in_accept_set(s1_byte_r)) begin
        echo_v_nxt = 1'b1;
        echo_b_nxt = s1_byte_r;
        if (field_r != tssp_pkg::FIELD_NONE) begin
          if (digit_r != 2'd2) begin
            case (field_r)
              3'd0: time_nxt[23:16] = (digit_r == 2'd0) ? hi_byte : (time_r[23:16] | v);
              3'd1: time_nxt[15:8]  = (digit_r == 2'd0) ? hi_byte : (time_r[15:8]  | v);
              3'd2: time_nxt[7:0]   = (digit_r == 2'd0) ? hi_byte : (time_r[7:0]   | v);
              3'd3: date_nxt[31:24] = (digit_r == 2'd0) ? hi_byte : (date_r[31:24] | v);
              3'd4: date_nxt[23:16] = (digit_r == 2'd0) ? hi_byte : (date_r[23:16] | v);
              3'd5: date_nxt[15:8]  = (digit_r == 2'd0) ? hi_byte : (date_r[15:8]  | v);
              3'd6: date_nxt[7:0]   = (digit_r == 2'd0) ? hi_byte : (date_r[7:0]   | v);
              default: ;
            endcase
          end
        end else if (count_r >= tssp_pkg::WAKEUP_FIRST && count_r <= tssp_pkg::WAKEUP_LAST) begin
          wake_nxt = (wake_sum[19:16] != 4'd0) ? tssp_pkg::WAKEUP_MAX : wake_sum[15:0];
        end
        // position p held as field p/3 (saturating) and digit p mod 3
        if (digit_r == 2'd2) begin
          digit_nxt = 2'd0;
          if (field_r != tssp_pkg::FIELD_NONE) begin
            field_nxt = field_r + 3'd1;
          end
        end else begin
          digit_nxt = digit_r + 2'd1;
        end
        count_nxt = count_inc;
        led_nxt   = !led_r;
        if (count_inc >= string_length_r) begin
          finish_nxt = tssp_pkg::STATUS_DONE;
          led_nxt    = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      synced_r    <= 1'b0;
      count_r     <= '0;
      digit_r     <= '0;
      field_r     <= '0;
      led_r       <= 1'b0;
      tmo_r       <= '0;
      finish_r    <= tssp_pkg::STATUS_COLLECT;
      time_r      <= '0;
      date_r      <= '0;
      wake_r      <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (process) begin
        synced_r <= synced_nxt;
        count_r  <= count_nxt;
        digit_r  <= digit_nxt;
        field_r  <= field_nxt;
        led_r    <= led_nxt;
        tmo_r    <= tmo_nxt;
        finish_r <= finish_nxt;
        time_r   <= time_nxt;
        date_r   <= date_nxt;
        wake_r   <= wake_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      s1_op_r   <= in_operation;
      s1_byte_r <= in_rx_byte;
    end
    if (process) begin
      echo_v_r <= echo_v_nxt;
      echo_b_r <= echo_b_nxt;
      menu_r   <= menu_nxt;
    end
  end

  // fields come straight from the state registers, which move with the result register
  assign out_valid          = out_valid_r;
  assign out_echo_valid     = echo_v_r;
  assign out_echo_byte      = echo_b_r;
  assign out_show_menu      = menu_r;
  assign out_status         = finish_r;
  assign out_led_on         = (finish_r == tssp_pkg::STATUS_COLLECT) ? led_r : 1'b0;
  assign out_time_bcd       = time_r;
  assign out_date_bcd       = date_r;
  assign out_wakeup_seconds = wake_r;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled without a full pipeline");

  a_finish_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (finish_r != tssp_pkg::STATUS_COLLECT) |=> $stable(finish_r))
    else $error("finished status changed");

  a_menu_no_echo: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && menu_r) |-> !echo_v_r)
    else $error("menu request together with echo");

  a_echo_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && echo_v_r) |-> (echo_b_r != 8'h00))
    else $error("echo of a byte outside the kept set");

  a_sync_before_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != 6'd0) |-> synced_r)
    else $error("characters counted before sync");

endmodule
`default_nettype wire
